/* sv/tpw_pkg.sv */
package tpw_pkg;

   // Page geometry.
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int COPY_CELLS = COLUMNS * (ROWS - 1);
   localparam int PAGE_BYTES = CELL_COUNT * 2;

   // Internal widths.
   localparam int CELL_W = $clog2(CELL_COUNT);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);

   // Scan counter landmarks.
   localparam logic [CELL_W-1:0] SCAN_ROW  = CELL_W'(COLUMNS);
   localparam logic [CELL_W-1:0] SCAN_COPY = CELL_W'(COPY_CELLS);
   localparam logic [CELL_W-1:0] SCAN_LAST = CELL_W'(CELL_COUNT - 1);

   // Cell contents.
   localparam logic [15:0] BLANK_CELL = 16'h0720;
   localparam logic [7:0]  TEXT_ATTR  = 8'h07;

   // Control characters.
   localparam logic [7:0] CH_BS = 8'd8;
   localparam logic [7:0] CH_LF = 8'd10;
   localparam logic [7:0] CH_CR = 8'd13;

   // Item kinds.
   typedef enum logic [1:0] {
      FUNC_TTY   = 2'd0,
      FUNC_CLEAR = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_WRITE = 2'd3
   } func_type;

   // Page memory access from the sequencer.
   typedef struct packed {
      logic              we;
      logic [CELL_W-1:0] waddr;
      logic [15:0]       wdata;
      logic [CELL_W-1:0] raddr;
   } mem_req_type;

   // One finished result.
   typedef struct packed {
      logic [4:0] cursor_row;
      logic [6:0] cursor_col;
      logic [7:0] read_byte;
   } result_type;

endpackage

/* sv/tpw_ram.sv */
module tpw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port, one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* sv/tpw_seq.sv */
module tpw_seq import tpw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  func_type    req_func,
   input  logic [7:0]  req_char,
   input  logic [11:0] req_addr,
   input  logic [7:0]  req_wbyte,
   input  logic        out_free,
   output logic        done_valid,
   output result_type  done_res,
   output mem_req_type mem_req,
   input  logic [15:0] mem_rdata
);

   typedef enum logic [2:0] {
      S_BOOT,
      S_IDLE,
      S_EXEC,
      S_RMW,
      S_SCROLL,
      S_FILL,
      S_DONE
   } state_type;

   state_type         state_ff, state_in;
   func_type          func_ff, func_in;
   logic [7:0]        char_ff, char_in;
   logic [11:0]       addr_ff, addr_in;
   logic [7:0]        wbyte_ff, wbyte_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [CELL_W-1:0] base_ff, base_in;
   logic [CELL_W-1:0] scan_ff, scan_in;
   logic [7:0]        rd_ff, rd_in;

   logic [CELL_W-1:0] cursor_cell;
   logic [CELL_W-1:0] raw_cell;
   logic              in_range;
   logic              last_col;
   logic              last_row;
   logic              newline;

   // Cursor cell comes from the running row base, so no multiply is needed.
   assign cursor_cell = base_ff + CELL_W'(col_ff);
   assign raw_cell    = CELL_W'(addr_ff[11:1]);
   assign in_range    = 32'(addr_ff) < PAGE_BYTES;
   assign last_col    = col_ff == COL_W'(COLUMNS - 1);
   assign last_row    = row_ff == ROW_W'(ROWS - 1);

   assign req_ready = state_ff == S_IDLE;
   assign done_res  = '{cursor_row: 5'(row_ff), cursor_col: 7'(col_ff), read_byte: rd_ff};

   // Sequencer next-state and memory port control.
   always_comb begin
      state_in    = state_ff;
      func_in     = func_ff;
      char_in     = char_ff;
      addr_in     = addr_ff;
      wbyte_in    = wbyte_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      base_in     = base_ff;
      scan_in     = scan_ff;
      rd_in       = rd_ff;
      newline     = 1'b0;
      done_valid  = 1'b0;
      mem_req     = '{we: 1'b0, waddr: scan_ff, wdata: BLANK_CELL, raddr: scan_ff};

      case (state_ff)
         S_BOOT: begin
            // Blank the whole page after reset.
            mem_req.we = 1'b1;
            if (scan_ff == SCAN_LAST) begin
               scan_in  = '0;
               state_in = S_IDLE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               func_in  = req_func;
               char_in  = req_char;
               addr_in  = req_addr;
               wbyte_in = req_wbyte;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            rd_in    = '0;
            state_in = S_DONE;
            case (func_ff)
               FUNC_TTY: begin
                  case (char_ff)
                     CH_BS: begin
                        if (col_ff != '0) begin
                           col_in = col_ff - 1'b1;
                        end
                     end
                     CH_CR: col_in = '0;
                     CH_LF: newline = 1'b1;
                     default: begin
                        // Printable byte: store it, then advance the cursor.
                        mem_req.we    = 1'b1;
                        mem_req.waddr = cursor_cell;
                        mem_req.wdata = {TEXT_ATTR, char_ff};
                        if (last_col) begin
                           col_in  = '0;
                           newline = 1'b1;
                        end else begin
                           col_in = col_ff + 1'b1;
                        end
                     end
                  endcase
                  if (newline) begin
                     if (last_row) begin
                        scan_in  = '0;
                        state_in = S_SCROLL;
                     end else begin
                        row_in  = row_ff + 1'b1;
                        base_in = base_ff + SCAN_ROW;
                     end
                  end
               end
               FUNC_CLEAR: begin
                  col_in   = '0;
                  row_in   = '0;
                  base_in  = '0;
                  scan_in  = '0;
                  state_in = S_FILL;
               end
               FUNC_READ, FUNC_WRITE: begin
                  if (in_range) begin
                     mem_req.raddr = raw_cell;
                     state_in      = S_RMW;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_RMW: begin
            // Read data for the raw access has arrived.
            if (func_ff == FUNC_READ) begin
               rd_in = addr_ff[0] ? mem_rdata[15:8] : mem_rdata[7:0];
            end else begin
               mem_req.we    = 1'b1;
               mem_req.waddr = raw_cell;
               mem_req.wdata = addr_ff[0] ? {wbyte_ff, mem_rdata[7:0]}
                                          : {mem_rdata[15:8], wbyte_ff};
            end
            state_in = S_DONE;
         end
         S_SCROLL: begin
            // Read one row below, write the cell read the cycle before.
            if (scan_ff < SCAN_COPY) begin
               mem_req.raddr = scan_ff + SCAN_ROW;
            end
            if (scan_ff != '0) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = scan_ff - 1'b1;
               mem_req.wdata = mem_rdata;
            end
            if (scan_ff == SCAN_COPY) begin
               state_in = S_FILL;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_FILL: begin
            // Blank cells from the scan position to the end of the page.
            mem_req.we = 1'b1;
            if (scan_ff == SCAN_LAST) begin
               state_in = S_DONE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (out_free) begin
               done_valid = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_BOOT;
         col_ff   <= '0;
         row_ff   <= '0;
         base_ff  <= '0;
         scan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         base_ff  <= base_in;
         scan_ff  <= scan_in;
      end
      func_ff  <= func_in;
      char_ff  <= char_in;
      addr_ff  <= addr_in;
      wbyte_ff <= wbyte_in;
      rd_ff    <= rd_in;
   end

endmodule

/* sv/text_page_teletype_writer_unit.sv */
// A teletype item without scroll goes from execute straight to done; a raw read or write inside
// the page adds a read-modify-write step (beyond it, it does not); a scroll copies the rows up
// and blanks the last row, and a clear page blanks every cell; one memory port walks cells.
// Throughput: one item at a time; the next item is taken only once the result has entered
// the output register. Reset clears the cursor and blanks the page in a sweep during which
// req_tready stays low.
module text_page_teletype_writer_unit import tpw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // char_code[7:0], byte_addr[19:8], write_byte[27:20]
   input  logic [1:0]  req_tuser,  // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // read_byte[7:0], cursor_col[14:8], cursor_row[19:15]
);

   mem_req_type mem_req;
   logic [15:0] mem_rdata;
   logic        out_free;
   logic        done_valid;
   result_type  done_res;
   logic        rsp_valid_ff;
   logic [23:0] rsp_data_ff;

   tpw_ram #(
      .WIDTH(16),
      .DEPTH(CELL_COUNT)
   ) u_page (
      .clock (clock),
      .we    (mem_req.we),
      .waddr (mem_req.waddr),
      .wdata (mem_req.wdata),
      .raddr (mem_req.raddr),
      .rdata (mem_rdata)
   );

   tpw_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_func   (func_type'(req_tuser)),
      .req_char   (req_tdata[7:0]),
      .req_addr   (req_tdata[19:8]),
      .req_wbyte  (req_tdata[27:20]),
      .out_free   (out_free),
      .done_valid (done_valid),
      .done_res   (done_res),
      .mem_req    (mem_req),
      .mem_rdata  (mem_rdata)
   );

   // Output register: the slot is free when empty or being taken this cycle.
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (done_valid) begin
         rsp_data_ff <= {4'b0, done_res};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* sv/tpw_check.sv */
module tpw_check import tpw_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // The reported cursor always lies on the page.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[14:8] < COLUMNS) && (rsp_tdata[19:15] < ROWS))
      else $error("cursor off the page");

   // The page sweep after reset keeps the input closed.
   assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_tready)
      else $error("input open during the reset sweep");

   // Every item keeps the block busy for at least the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken back to back");

endmodule

bind text_page_teletype_writer_unit tpw_check u_check (.*);

/* verif/text_page_teletype_writer_unit_test.sv */
module text_page_teletype_writer_unit_test;
   import tpw_pkg::*;

   localparam int    HALF_PERIOD = 6;
   localparam int    RESET_CYCLES = 11;
   localparam int    LONG_HOLD_CYCLES = 80;
   localparam int    SETTLE_CYCLES = CELL_COUNT + 16;
   localparam longint RUN_LIMIT = 64'd4000000 * 2 * HALF_PERIOD;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // char_code[7:0], byte_addr[19:8], write_byte[27:20]
   logic [1:0]  req_tuser;   // func[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // read_byte[7:0], cursor_col[14:8], cursor_row[19:15]

   // Shadow copy of the page and cursor, updated as each item is accepted.
   logic [15:0] page_cells [CELL_COUNT];
   int          cur_col;
   int          cur_row;

   // Results still owed by the block, oldest first.
   result_type  expected_results [$];
   result_type  want_result;
   result_type  got_result;
   int          error_count = 0;

   // Idle and stall controls for the sender and the receiver.
   bit          req_idle_on = 1'b1;
   bit          rsp_stall_on = 1'b1;
   bit          rsp_long_hold = 1'b0;
   int          rsp_hold_left = 0;

   text_page_teletype_writer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Page model.

   function automatic void blank_page();
      for (int i = 0; i < CELL_COUNT; i++) page_cells[i] = BLANK_CELL;
      cur_col = 0;
      cur_row = 0;
   endfunction

   function automatic void scroll_page();
      for (int i = 0; i < COPY_CELLS; i++) page_cells[i] = page_cells[i + COLUMNS];
      for (int i = COPY_CELLS; i < CELL_COUNT; i++) page_cells[i] = BLANK_CELL;
   endfunction

   // Cursor motion for control characters; anything else is printed and advances.
   function automatic void teletype_char(input logic [7:0] ch);
      int row;
      row = cur_row;
      if (ch == CH_BS) begin
         if (cur_col > 0) cur_col--;
      end else if (ch == CH_CR) begin
         cur_col = 0;
      end else if (ch == CH_LF) begin
         row++;
      end else begin
         page_cells[row * COLUMNS + cur_col] = {TEXT_ATTR, ch};
         if (cur_col >= COLUMNS - 1) begin
            cur_col = 0;
            row++;
         end else begin
            cur_col++;
         end
      end
      // Falling off the bottom scrolls the page and pins the cursor to the last row.
      if (row >= ROWS) begin
         row = ROWS - 1;
         scroll_page();
      end
      cur_row = row;
   endfunction

   function automatic result_type predict_page_item(input func_type fn, input logic [7:0] ch,
         input logic [11:0] addr, input logic [7:0] wb);
      result_type  r;
      logic [15:0] word;
      r = '0;
      case (fn)
         FUNC_TTY: begin
            teletype_char(ch);
         end
         FUNC_CLEAR: begin
            blank_page();
         end
         default: begin
            // Raw access; addresses past the page read zero and drop writes.
            if (addr < PAGE_BYTES) begin
               word = page_cells[addr >> 1];
               if (fn == FUNC_READ) begin
                  r.read_byte = addr[0] ? word[15:8] : word[7:0];
               end else begin
                  if (addr[0]) word[15:8] = wb;
                  else word[7:0] = wb;
                  page_cells[addr >> 1] = word;
               end
            end
         end
      endcase
      r.cursor_col = 7'(cur_col);
      r.cursor_row = 5'(cur_row);
      return r;
   endfunction

   // Sender: optional idle burst, then offer one item until the block takes it.
   task automatic send_item(input func_type fn, input logic [7:0] ch, input logic [11:0] addr,
         input logic [7:0] wb);
      @(negedge clock);
      if (req_idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = fn;
      req_tdata = {4'b0, wb, addr, ch};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_results.push_back(predict_page_item(fn, ch, addr, wb));
   endtask

   // Stop offering items and let every owed result come back.
   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic type_char(input logic [7:0] ch);
      send_item(FUNC_TTY, ch, 12'($urandom), 8'($urandom));
   endtask

   task automatic read_byte_at(input logic [11:0] addr);
      send_item(FUNC_READ, 8'($urandom), addr, 8'($urandom));
   endtask

   task automatic write_byte_at(input logic [11:0] addr, input logic [7:0] wb);
      send_item(FUNC_WRITE, 8'($urandom), addr, wb);
   endtask

   task automatic clear_page();
      send_item(FUNC_CLEAR, 8'($urandom), 12'($urandom), 8'($urandom));
   endtask

   // Stimulus helpers.

   function automatic logic [7:0] random_glyph();
      logic [7:0] v;
      v = 8'($urandom_range(0, 255));
      while (v == CH_BS || v == CH_LF || v == CH_CR) v = 8'($urandom_range(0, 255));
      return v;
   endfunction

   function automatic logic [7:0] random_char();
      case ($urandom_range(0, 11))
         0: return CH_BS;
         1: return CH_CR;
         2: return CH_LF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Mostly addresses on the cursor row, where the text is, some past the page.
   function automatic logic [11:0] pick_page_address();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 12'($urandom_range(PAGE_BYTES, 4095));
      else if (r < 6)
         return 12'((cur_row * COLUMNS + $urandom_range(0, COLUMNS - 1)) * 2
                    + $urandom_range(0, 1));
      else return 12'($urandom_range(0, PAGE_BYTES - 1));
   endfunction

   task automatic probe_page();
      if ($urandom_range(0, 1) == 0) read_byte_at(pick_page_address());
      else write_byte_at(pick_page_address(), 8'($urandom));
   endtask

   task automatic send_random_item();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 3) clear_page();
      else if (pick < 55) type_char(random_char());
      else if (pick < 78) read_byte_at(pick_page_address());
      else write_byte_at(pick_page_address(), 8'($urandom));
   endtask

   // Tests.

   // Raw access on the blank page, including both page ends and beyond.
   task automatic test_page_access();
      read_byte_at(12'd0);
      read_byte_at(12'd1);
      read_byte_at(12'(PAGE_BYTES - 2));
      read_byte_at(12'(PAGE_BYTES - 1));
      read_byte_at(12'(PAGE_BYTES));
      write_byte_at(12'hFFF, 8'hFF);
      read_byte_at(12'hFFF);
      write_byte_at(12'd0, 8'hFF);
      write_byte_at(12'd1, 8'h00);
      read_byte_at(12'd0);
      read_byte_at(12'd1);
      write_byte_at(12'(PAGE_BYTES - 1), 8'hAB);
      read_byte_at(12'(PAGE_BYTES - 1));
      wait_for_results();
   endtask

   // Backspace at the left edge, return, line feed, extreme glyphs and clear.
   task automatic test_cursor_controls();
      type_char(CH_BS);
      type_char(8'h00);
      type_char(8'hFF);
      type_char(CH_BS);
      type_char(CH_BS);
      type_char(CH_BS);
      type_char(CH_CR);
      type_char(CH_LF);
      type_char(8'h41);
      read_byte_at(12'd0);
      read_byte_at(12'd2);
      read_byte_at(12'(COLUMNS * 2));
      read_byte_at(12'(COLUMNS * 2 + 1));
      clear_page();
      read_byte_at(12'(COLUMNS * 2));
      wait_for_results();
   endtask

   // Wrap in mid page, then wrap and line feed on the last row, both of which scroll.
   task automatic test_wrap_and_scroll();
      clear_page();
      repeat (COLUMNS) type_char(random_glyph());
      repeat (ROWS - 2) type_char(CH_LF);
      repeat (COLUMNS) type_char(random_glyph());
      type_char(CH_LF);
      repeat (3) type_char(random_glyph());
      repeat (6) read_byte_at(12'($urandom_range(COPY_CELLS * 2 - 2 * COLUMNS, PAGE_BYTES - 1)));
      read_byte_at(12'd0);
      wait_for_results();
   endtask

   // Lines of random text with line endings, broken endings and page probes.
   task automatic test_text_lines();
      int sent;
      int line_len;
      sent = 0;
      while (sent < 100) begin
         if ($urandom_range(0, 19) == 0) line_len = $urandom_range(COLUMNS - 4, COLUMNS + 6);
         else line_len = $urandom_range(0, 4);
         repeat (line_len) begin
            type_char(random_glyph());
            sent++;
            if ($urandom_range(0, 7) == 0) begin
               probe_page();
               sent++;
            end
         end
         case ($urandom_range(0, 7))
            0: begin
               type_char(CH_LF);
            end
            1: begin
               repeat ($urandom_range(1, 3)) type_char(CH_BS);
               type_char(CH_CR);
            end
            2: begin
               send_random_item();
            end
            default: begin
               type_char(CH_CR);
               repeat ($urandom_range(1, 3)) type_char(CH_LF);
            end
         endcase
         sent += 2;
      end
      wait_for_results();
   endtask

   task automatic test_random_mix(input int count);
      repeat (count) send_random_item();
      wait_for_results();
   endtask

   // The receiver stops for a long while; the sender keeps pushing until the block stalls.
   task automatic test_output_backpressure();
      rsp_long_hold = 1'b1;
      repeat (12) send_random_item();
      wait_for_results();
   endtask

   // Receiver: random stalls, long hold on request, otherwise always ready.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_tready = 1'b0;
            rsp_hold_left--;
         end else if (rsp_long_hold) begin
            rsp_long_hold = 1'b0;
            rsp_hold_left = LONG_HOLD_CYCLES - 1;
            rsp_tready = 1'b0;
         end else if (rsp_stall_on && $urandom_range(0, 5) == 0) begin
            rsp_hold_left = $urandom_range(0, 3);
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   // Result checker: each item taken is matched against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("result with no item outstanding: rsp_tdata=%h", rsp_tdata);
            error_count++;
         end else begin
            want_result = expected_results.pop_front();
            got_result = rsp_tdata[19:0];
            compare_field("read_byte", want_result.read_byte, got_result.read_byte);
            compare_field("cursor_col", want_result.cursor_col, got_result.cursor_col);
            compare_field("cursor_row", want_result.cursor_row, got_result.cursor_row);
         end
      end
   end

   initial begin
      #(RUN_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = FUNC_TTY;
      blank_page();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_page_access();
      test_cursor_controls();
      test_wrap_and_scroll();
      test_text_lines();
      test_random_mix(60);
      test_output_backpressure();

      // Closing stretch without idle cycles on either side.
      req_idle_on = 1'b0;
      rsp_stall_on = 1'b0;
      test_random_mix(30);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
